@@ rtl/usfn_pkg.sv @@
package usfn_pkg;

  localparam int unsigned MaxSeqLen  = 5;
  localparam int unsigned QueueDepth = 6;

  localparam int unsigned LenWidth = $clog2(MaxSeqLen + 1);
  localparam int unsigned CpWidth  = 21;

  typedef logic [7:0] byte_t;
  typedef logic [LenWidth-1:0] len_t;

  typedef struct packed {
    byte_t [MaxSeqLen-1:0] seq;
    len_t                  len;
    logic                  bad;
  } usfn_rec_t;

endpackage

@@ rtl/usfn_in_if.sv @@
interface usfn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

@@ rtl/usfn_out_if.sv @@
interface usfn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       bad_lead;

  modport source (output valid, output out_byte, output last_of_run, output bad_lead,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input bad_lead,
                output ready);
endinterface

@@ rtl/utf8_shortest_form_normalizer.sv @@
// UTF-8 shortest-form normalizer.
// The in_i channel takes one raw stream byte per transaction; the out_o channel
// gives one normalized byte per transaction, with last_of_run marking the final
// byte of a character and bad_lead marking a dropped invalid lead byte.
// Both channels use valid/ready; a transaction happens when both are high.
// Each side moves one byte per cycle while it is not stalled. The front pushes a
// character into the queue at the edge that accepts its final byte, and an idle
// back end then loads it from the queue into its output shift register, from
// which its first output byte is offered.
// The front collects bytes of a character and pushes one record into a small
// queue; the back re-encodes it and emits its bytes from a shift register, one
// per cycle while out_o.ready is high. The queue holds six records, enough to
// keep in_i.ready high while a five-byte character drains ahead of single bytes.
// While the receiver stalls the output byte holds, the queue fills,
// and in_i.ready drops once the queue is full.
// Reset clears the open sequence, the queue and the output byte count; no byte
// is pending afterwards.
module utf8_shortest_form_normalizer #(
  parameter int unsigned QUEUE_DEPTH = usfn_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  usfn_in_if.sink     in_i,
  usfn_out_if.source  out_o
);
  import usfn_pkg::*;

  logic      push;
  logic      full;
  logic      pop;
  logic      head_valid;
  usfn_rec_t push_rec;
  usfn_rec_t head_rec;

  usfn_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .rec_o  (push_rec)
  );

  usfn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rec_o   (head_rec)
  );

  usfn_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .rec_i   (head_rec),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

@@ rtl/usfn_front.sv @@
module usfn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  usfn_in_if.sink           in_i,
  input  logic              full_i,
  output logic              push_o,
  output usfn_pkg::usfn_rec_t rec_o
);
  import usfn_pkg::*;

  len_t                  exp_len_q, exp_len_d;
  len_t                  rcv_cnt_q, rcv_cnt_d;
  byte_t [MaxSeqLen-1:0] held_q;
  len_t                  lead_len;
  len_t                  rcv_next;
  logic                  accept;

  always_comb begin
    priority casez (in_i.in_byte)
      8'b0???????: lead_len = len_t'(1);
      8'b10??????: lead_len = len_t'(0);
      8'b110?????: lead_len = len_t'(2);
      8'b1110????: lead_len = len_t'(3);
      8'b11110???: lead_len = len_t'(4);
      8'b111110??: lead_len = len_t'(5);
      default:     lead_len = len_t'(0);
    endcase
  end

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign rcv_next   = rcv_cnt_q + len_t'(1);

  always_comb begin
    exp_len_d = exp_len_q;
    rcv_cnt_d = rcv_cnt_q;
    push_o    = 1'b0;
    rec_o.seq = held_q;
    rec_o.len = exp_len_q;
    rec_o.bad = 1'b0;
    if (accept) begin
      if (exp_len_q == '0) begin
        rec_o.seq[0] = in_i.in_byte;
        rec_o.len    = len_t'(1);
        if (lead_len == '0) begin
          push_o       = 1'b1;
          rec_o.seq[0] = '0;
          rec_o.bad    = 1'b1;
        end else if (lead_len == len_t'(1)) begin
          push_o = 1'b1;
        end else begin
          exp_len_d = lead_len;
          rcv_cnt_d = len_t'(1);
        end
      end else begin
        rec_o.seq[rcv_cnt_q] = in_i.in_byte;
        rcv_cnt_d            = rcv_next;
        if (rcv_next == exp_len_q) begin
          push_o    = 1'b1;
          exp_len_d = '0;
          rcv_cnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0;
      rcv_cnt_q <= '0;
    end else begin
      exp_len_q <= exp_len_d;
      rcv_cnt_q <= rcv_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (exp_len_q == '0) begin
        held_q[0] <= in_i.in_byte;
      end else begin
        held_q[rcv_cnt_q] <= in_i.in_byte;
      end
    end
  end

endmodule

@@ rtl/usfn_queue.sv @@
module usfn_queue #(
  parameter int unsigned DEPTH = usfn_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  usfn_pkg::usfn_rec_t rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output usfn_pkg::usfn_rec_t rec_o
);
  import usfn_pkg::*;

  localparam int unsigned PtrWidth = $clog2(DEPTH);
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  usfn_rec_t             entry_q [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == CntWidth'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

@@ rtl/usfn_back.sv @@
module usfn_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  usfn_pkg::usfn_rec_t rec_i,
  output logic                pop_o,
  usfn_out_if.source          out_o
);
  import usfn_pkg::*;

  byte_t [MaxSeqLen-1:0] buf_q, buf_d;
  len_t                  cnt_q, cnt_d;
  logic                  bad_q, bad_d;
  logic [CpWidth-1:0]    cp;
  len_t                  short_len;
  byte_t [MaxSeqLen-1:0] enc;
  logic                  keep_raw;
  logic                  take;

  always_comb begin
    unique case (rec_i.len)
      len_t'(2): cp = CpWidth'({rec_i.seq[0][4:0], rec_i.seq[1][5:0]});
      len_t'(3): cp = CpWidth'({rec_i.seq[0][3:0], rec_i.seq[1][5:0], rec_i.seq[2][5:0]});
      len_t'(4): cp = {rec_i.seq[0][2:0], rec_i.seq[1][5:0], rec_i.seq[2][5:0],
                       rec_i.seq[3][5:0]};
      default:   cp = CpWidth'(rec_i.seq[0][6:0]);
    endcase
  end

  always_comb begin
    if (cp > CpWidth'(24'h00FFFF)) begin
      short_len = len_t'(4);
    end else if (cp > CpWidth'(24'h0007FF)) begin
      short_len = len_t'(3);
    end else if (cp > CpWidth'(24'h00007F)) begin
      short_len = len_t'(2);
    end else begin
      short_len = len_t'(1);
    end
  end

  always_comb begin
    enc = '0;
    unique case (short_len)
      len_t'(1): begin
        enc[0] = {1'b0, cp[6:0]};
      end
      len_t'(2): begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      len_t'(3): begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
  end

  assign keep_raw = (rec_i.len == len_t'(5)) || (rec_i.len < len_t'(2)) ||
                    (short_len == rec_i.len);

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_byte    = buf_q[0];
  assign out_o.last_of_run = (cnt_q == len_t'(1));
  assign out_o.bad_lead    = bad_q;

  assign take  = out_o.valid && out_o.ready;
  assign pop_o = valid_i && ((cnt_q == '0) || ((cnt_q == len_t'(1)) && take));

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    bad_d = bad_q;
    if (pop_o) begin
      buf_d = keep_raw ? rec_i.seq : enc;
      cnt_d = keep_raw ? rec_i.len : short_len;
      bad_d = rec_i.bad;
    end else if (take) begin
      for (int i = 0; i < MaxSeqLen - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      cnt_d = cnt_q - len_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    bad_q <= bad_d;
  end

endmodule
